// ----- rtl/core/lpd_pkg.sv -----
`timescale 1ns / 1ps

package lpd_pkg;

   localparam int unsigned ByteWidth   = 8;
   localparam int unsigned LengthWidth = 32;
   localparam int unsigned AccumWidth  = 24;
   localparam int unsigned CountWidth  = 2;

   localparam logic [LengthWidth-1:0] MaxLengthReset = LengthWidth'(16 * 1024 * 1024);

   localparam logic [CountWidth-1:0] HeaderLastCount = CountWidth'(3);

   typedef struct packed {
      logic                 valid;
      logic [ByteWidth-1:0] data;
   } byte_stage_type;

   typedef struct packed {
      logic [ByteWidth-1:0] out_byte;
      logic                 last_of_message;
      logic                 oversize_error;
   } result_type;

endpackage

// ----- rtl/core/lpd_ifs.sv -----
`timescale 1ns / 1ps

interface lpd_req_if;
   logic                           valid;
   logic                           ready;
   logic [lpd_pkg::ByteWidth-1:0]  in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink (input valid, input in_byte, output ready);
endinterface

interface lpd_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [lpd_pkg::ByteWidth-1:0]  out_byte;
   logic                           last_of_message;
   logic                           oversize_error;

   modport source (output valid, output out_byte, output last_of_message,
                   output oversize_error, input ready);
   modport sink (input valid, input out_byte, input last_of_message,
                 input oversize_error, output ready);
endinterface

interface lpd_csr_if;
   logic                            valid;
   logic                            ready;
   logic [lpd_pkg::LengthWidth-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/lpd_in_stage.sv -----
`timescale 1ns / 1ps

module lpd_in_stage (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [lpd_pkg::ByteWidth-1:0] in_byte,
   output logic                          in_ready,
   input  logic                          advance,
   output lpd_pkg::byte_stage_type       stage
);

   logic                          valid_ff;
   logic                          valid_in;
   logic [lpd_pkg::ByteWidth-1:0] data_ff;
   logic [lpd_pkg::ByteWidth-1:0] data_in;

   assign in_ready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (in_valid && in_ready) begin
         valid_in = 1'b1;
         data_in  = in_byte;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign stage.valid = valid_ff;
   assign stage.data  = data_ff;

endmodule

// ----- rtl/core/lpd_parse.sv -----
`timescale 1ns / 1ps

module lpd_parse (
   input  logic                            clock,
   input  logic                            reset,
   input  lpd_pkg::byte_stage_type         stage,
   output logic                            advance,
   input  logic                            csr_valid,
   input  logic [lpd_pkg::LengthWidth-1:0] csr_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output lpd_pkg::result_type             rsp_data
);

   logic [lpd_pkg::LengthWidth-1:0] max_length_ff;
   logic [lpd_pkg::LengthWidth-1:0] max_length_in;
   logic [lpd_pkg::CountWidth-1:0]  header_count_ff;
   logic [lpd_pkg::CountWidth-1:0]  header_count_in;
   logic [lpd_pkg::AccumWidth-1:0]  header_accum_ff;
   logic [lpd_pkg::AccumWidth-1:0]  header_accum_in;
   logic [lpd_pkg::LengthWidth-1:0] bytes_remaining_ff;
   logic [lpd_pkg::LengthWidth-1:0] bytes_remaining_in;
   logic                            closed_ff;
   logic                            closed_in;
   logic                            out_valid_ff;
   logic                            out_valid_in;
   lpd_pkg::result_type             out_ff;
   lpd_pkg::result_type             out_in;
   logic [lpd_pkg::LengthWidth-1:0] header_length;
   logic                            in_body;

   assign advance       = stage.valid && (!out_valid_ff || rsp_ready);
   assign header_length = {stage.data, header_accum_ff};
   assign in_body       = (bytes_remaining_ff != '0);
   assign max_length_in = csr_valid ? csr_data : max_length_ff;

   always_comb begin
      header_count_in    = header_count_ff;
      header_accum_in    = header_accum_ff;
      bytes_remaining_in = bytes_remaining_ff;
      closed_in          = closed_ff;
      out_valid_in       = out_valid_ff && !rsp_ready;
      out_in             = out_ff;
      if (advance) begin
         out_valid_in = 1'b0;
         if (!closed_ff) begin
            if (in_body) begin
               bytes_remaining_in     = bytes_remaining_ff - lpd_pkg::LengthWidth'(1);
               out_valid_in           = 1'b1;
               out_in.out_byte        = stage.data;
               out_in.last_of_message = (bytes_remaining_ff == lpd_pkg::LengthWidth'(1));
               out_in.oversize_error  = 1'b0;
            end else if (header_count_ff != lpd_pkg::HeaderLastCount) begin
               header_count_in = header_count_ff + lpd_pkg::CountWidth'(1);
               case (header_count_ff)
                  2'd0:    header_accum_in[7:0]   = stage.data;
                  2'd1:    header_accum_in[15:8]  = stage.data;
                  default: header_accum_in[23:16] = stage.data;
               endcase
            end else begin
               header_count_in = '0;
               header_accum_in = '0;
               if (header_length > max_length_ff) begin
                  closed_in              = 1'b1;
                  out_valid_in           = 1'b1;
                  out_in.out_byte        = '0;
                  out_in.last_of_message = 1'b0;
                  out_in.oversize_error  = 1'b1;
               end else begin
                  bytes_remaining_in = header_length;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_length_ff      <= lpd_pkg::MaxLengthReset;
         header_count_ff    <= '0;
         header_accum_ff    <= '0;
         bytes_remaining_ff <= '0;
         closed_ff          <= 1'b0;
         out_valid_ff       <= 1'b0;
      end else begin
         max_length_ff      <= max_length_in;
         header_count_ff    <= header_count_in;
         header_accum_ff    <= header_accum_in;
         bytes_remaining_ff <= bytes_remaining_in;
         closed_ff          <= closed_in;
         out_valid_ff       <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

`ifndef SYNTHESIS
   a_error_closes: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.oversize_error) |-> closed_ff)
      else $error("error result without closed stream");

   a_closed_sticks: assert property (@(posedge clock) disable iff (reset)
      closed_ff |=> closed_ff)
      else $error("closed stream reopened");

   a_header_no_body: assert property (@(posedge clock) disable iff (reset)
      (header_count_ff != '0) |-> (bytes_remaining_ff == '0))
      else $error("header in progress while body remains");

   a_last_empties: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.last_of_message) |-> (bytes_remaining_ff == '0))
      else $error("last byte shown with body remaining");

   a_stall_holds_state: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_ready) |=> $stable(bytes_remaining_ff))
      else $error("state moved during output stall");
`endif

endmodule

// ----- rtl/core/length_prefixed_deframer.sv -----
`timescale 1ns / 1ps

// Length-prefixed deframer. Takes one stream byte per req transaction and
// returns each message body byte as one rsp transaction, flagging the last
// byte of each message. A message is a 4-byte little-endian length followed
// by that many body bytes; header bytes and zero-length messages return
// nothing. A length above max_length returns a single error transaction,
// after which every byte is dropped until reset. One byte per clock is
// sustained while rsp is ready: an input register feeds the parser, whose
// result register is the only output stage between req and rsp.
// max_length resets to 16 MiB and may be rewritten on csr at any time the
// block is idle; csr is always ready.

module length_prefixed_deframer (
   input  logic       clock,
   input  logic       reset,
   lpd_req_if.sink    req,
   lpd_rsp_if.source  rsp,
   lpd_csr_if.sink    csr
);

   lpd_pkg::byte_stage_type stage;
   lpd_pkg::result_type     result;
   logic                    advance;

   lpd_in_stage u_in_stage (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req.valid),
      .in_byte  (req.in_byte),
      .in_ready (req.ready),
      .advance  (advance),
      .stage    (stage)
   );

   lpd_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .stage     (stage),
      .advance   (advance),
      .csr_valid (csr.valid),
      .csr_data  (csr.data),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .rsp_data  (result)
   );

   assign csr.ready           = 1'b1;
   assign rsp.out_byte        = result.out_byte;
   assign rsp.last_of_message = result.last_of_message;
   assign rsp.oversize_error  = result.oversize_error;

endmodule
